// ===== rtl/integral_image_block_sum_assert.svh =====
// Assertion macros for the block-sum checker.
`ifndef INTEGRAL_IMAGE_BLOCK_SUM_ASSERT_SVH
`define INTEGRAL_IMAGE_BLOCK_SUM_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define IIBS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iibs: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define IIBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iibs: next-cycle check failed");

`endif

// ===== rtl/iibs_pkg.sv =====
// Types and constants of the summed-area block-sum engine.
`default_nettype none

package iibs_pkg;

  // Image geometry and channel count
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int Channels  = 3;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = ColW + RowW;
  localparam int Depth     = MaxWidth * MaxHeight;

  // Field widths
  localparam int PixW    = 8;
  localparam int PixSqW  = 2 * PixW;
  localparam int RowSumW = 14;
  localparam int RowSqW  = 22;
  localparam int SumW    = 20;
  localparam int SqW     = 28;
  localparam int DimW    = 7;
  localparam int PosW    = 6;
  localparam int ChW     = 2;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 7;

  // Largest channel count that the register may select
  localparam logic [ChW-1:0] MaxChannels = ChW'(Channels);

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk         = 2'd0,
    StatusOutside    = 2'd1,
    StatusIncomplete = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth    = 2'd0,
    CfgHeight   = 2'd1,
    CfgChannels = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StLoadWr,
    StQryB,
    StQryC
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/integral_image_block_sum.sv =====
// Top level: summed-area tables of values and squares with block-sum queries.
`default_nettype none

// Pixels (opcode 0) are loaded in raster order and build, per channel, a
// summed-area table of values and one of squared values; a query (opcode 1)
// returns per-channel block sums from four table corners. On a load, the
// entry above is read in the accept cycle and the new entry is written in
// the next. On a query, the two read ports of the table memories fetch two
// corners in the accept cycle and the other two in state StQryB; the sums
// are combined in StQryC and registered, and the result strobe
// result_valid_o is high for exactly one cycle, in which the block is already
// free for the next item. The receiver cannot stall: a result must be taken in
// its strobe cycle. The tables are not cleared after reset; a query before the
// frame is complete returns status 2. Configuration writes restart the frame.
module integral_image_block_sum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command handshake
  input  logic                           start_i,
  output logic                           busy_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [iibs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [iibs_pkg::CfgW-1:0]      cfg_data_i,
  // item fields
  input  logic                           opcode_i,
  input  logic [iibs_pkg::PixW-1:0]      chan0_i,
  input  logic [iibs_pkg::PixW-1:0]      chan1_i,
  input  logic [iibs_pkg::PixW-1:0]      chan2_i,
  input  logic [iibs_pkg::PosW-1:0]      x_start_i,
  input  logic [iibs_pkg::PosW-1:0]      y_start_i,
  input  logic [iibs_pkg::DimW-1:0]      block_w_i,
  input  logic [iibs_pkg::DimW-1:0]      block_h_i,
  // result
  output logic                           result_valid_o,
  output logic [iibs_pkg::SumW-1:0]      sum_c0_o,
  output logic [iibs_pkg::SumW-1:0]      sum_c1_o,
  output logic [iibs_pkg::SumW-1:0]      sum_c2_o,
  output logic [iibs_pkg::SqW-1:0]       sq_c0_o,
  output logic [iibs_pkg::SqW-1:0]       sq_c1_o,
  output logic [iibs_pkg::SqW-1:0]       sq_c2_o,
  output logic [iibs_pkg::StatusW-1:0]   status_o
);
  import iibs_pkg::*;

  typedef logic [Channels-1:0][SumW-1:0] sum_row_t;
  typedef logic [Channels-1:0][SqW-1:0]  sq_row_t;

  // Clamp a dimension register to 1..max
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers
  logic [DimW-1:0] width_q, height_q;
  logic [ChW-1:0]  nch_q;
  logic [DimW-1:0] eff_w, eff_h;
  logic [ChW-1:0]  eff_ch;

  // Control state
  state_e          state_q, state_d;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            frame_done_q;
  logic [Channels-1:0][RowSumW-1:0] rs_q;
  logic [Channels-1:0][RowSqW-1:0]  rq_q;

  // Load payload
  logic [Channels-1:0][PixW-1:0]   pix_in, pix_q;
  logic [Channels-1:0][PixSqW-1:0] pix_sq_d, pix_sq_q;
  logic                            above_zero_q;
  logic [Channels-1:0][RowSumW-1:0] rs_new;
  logic [Channels-1:0][RowSqW-1:0]  rq_new;
  sum_row_t        wr_sum;
  sq_row_t         wr_sq;
  logic            row_end, frame_end;

  // Query payload
  logic [DimW:0]   qx2, qy2;
  logic [ColW-1:0] qx2m1;
  logic [RowW-1:0] qy2m1;
  logic [PosW-1:0] qx1m1, qy1m1;
  logic            oob;
  status_e         qstatus;
  logic [AddrW-1:0] addr21_q, addr11_q;
  logic            z22_q, z12_q, z21_q, z11_q;
  status_e         status_q;
  sum_row_t        c22_sum_q, c12_sum_q;
  sq_row_t         c22_sq_q, c12_sq_q;

  // Memory ports
  logic             mem_we;
  logic [AddrW-1:0] addr_a, addr_b, addr_w;
  sum_row_t         sum_mem [Depth];
  sq_row_t          sq_mem [Depth];
  sum_row_t         rd_a_sum_q, rd_b_sum_q;
  sq_row_t          rd_a_sq_q, rd_b_sq_q;

  // Result registers
  logic     valid_q;
  sum_row_t res_sum_q, res_sum_d;
  sq_row_t  res_sq_q, res_sq_d;

  logic accept, load_acc, qry_acc;

  assign eff_w  = clamp_dim(width_q, DimW'(MaxWidth));
  assign eff_h  = clamp_dim(height_q, DimW'(MaxHeight));
  assign eff_ch = (nch_q == '0) ? ChW'(1) : ((nch_q > MaxChannels) ? MaxChannels : nch_q);

  assign busy_o   = (state_q != StIdle);
  assign accept   = start_i && !busy_o;
  assign load_acc = accept && (opcode_i == OpLoad);
  assign qry_acc  = accept && (opcode_i == OpQuery);

  // Query geometry and status at accept; far corner kept one bit wider so it never wraps
  assign qx2   = {2'b00, x_start_i} + {1'b0, block_w_i};
  assign qy2   = {2'b00, y_start_i} + {1'b0, block_h_i};
  assign qx2m1 = qx2[ColW-1:0] - 1'b1;
  assign qy2m1 = qy2[RowW-1:0] - 1'b1;
  assign qx1m1 = x_start_i - 1'b1;
  assign qy1m1 = y_start_i - 1'b1;
  assign oob   = (qx2 > {1'b0, eff_w}) || (qy2 > {1'b0, eff_h});

  always_comb begin
    if (!frame_done_q) begin
      qstatus = StatusIncomplete;
    end else if (oob) begin
      qstatus = StatusOutside;
    end else begin
      qstatus = StatusOk;
    end
  end

  // Pixel lanes and their squares
  assign pix_in[0] = chan0_i;
  assign pix_in[1] = chan1_i;
  assign pix_in[2] = chan2_i;

  always_comb begin
    for (int ch = 0; ch < Channels; ch++) begin
      pix_sq_d[ch] = pix_in[ch] * pix_in[ch];
    end
  end

  // State machine: next state and memory port control
  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    addr_a  = '0;
    addr_b  = '0;
    case (state_q)
      StIdle: begin
        if (qry_acc) begin
          addr_a  = {qy2m1, qx2m1};
          addr_b  = {qy1m1[RowW-1:0], qx2m1};
          state_d = StQryB;
        end else if (load_acc) begin
          addr_a  = {RowW'(row_q - 1'b1), col_q};
          state_d = StLoadWr;
        end
      end
      StLoadWr: begin
        mem_we  = 1'b1;
        state_d = StIdle;
      end
      StQryB: begin
        addr_a  = addr21_q;
        addr_b  = addr11_q;
        state_d = StQryC;
      end
      StQryC: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Table memories: one write port, two registered read ports
  assign addr_w = {row_q, col_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[addr_w] <= wr_sum;
      sq_mem[addr_w]  <= wr_sq;
    end
    rd_a_sum_q <= sum_mem[addr_a];
    rd_a_sq_q  <= sq_mem[addr_a];
    rd_b_sum_q <= sum_mem[addr_b];
    rd_b_sq_q  <= sq_mem[addr_b];
  end

  // New entries: running row sums plus the entry above
  always_comb begin
    for (int ch = 0; ch < Channels; ch++) begin
      rs_new[ch] = rs_q[ch] + RowSumW'(pix_q[ch]);
      rq_new[ch] = rq_q[ch] + RowSqW'(pix_sq_q[ch]);
      wr_sum[ch] = SumW'(rs_new[ch]) + (above_zero_q ? SumW'(0) : rd_a_sum_q[ch]);
      wr_sq[ch]  = SqW'(rq_new[ch]) + (above_zero_q ? SqW'(0) : rd_a_sq_q[ch]);
    end
  end

  assign row_end   = (({1'b0, col_q} + 1'b1) >= eff_w);
  assign frame_end = (({1'b0, row_q} + 1'b1) >= eff_h);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(MaxWidth);
      height_q <= DimW'(MaxHeight);
      nch_q    <= MaxChannels;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWidth:    width_q  <= cfg_data_i;
        CfgHeight:   height_q <= cfg_data_i;
        CfgChannels: nch_q    <= cfg_data_i[ChW-1:0];
        default:     ;
      endcase
    end
  end

  // Raster counters, running sums and frame flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      frame_done_q <= 1'b0;
      rs_q         <= '0;
      rq_q         <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CfgWidth || cfg_idx_i == CfgHeight ||
                              cfg_idx_i == CfgChannels)) begin
      col_q        <= '0;
      row_q        <= '0;
      frame_done_q <= 1'b0;
      rs_q         <= '0;
      rq_q         <= '0;
    end else if (load_acc) begin
      // counters and sums are already zero once a frame completes
      frame_done_q <= 1'b0;
    end else if (state_q == StLoadWr) begin
      if (row_end) begin
        col_q <= '0;
        rs_q  <= '0;
        rq_q  <= '0;
        if (frame_end) begin
          row_q        <= '0;
          frame_done_q <= 1'b1;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
        rs_q  <= rs_new;
        rq_q  <= rq_new;
      end
    end
  end

  // Item payload captured at accept
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      pix_q        <= pix_in;
      pix_sq_q     <= pix_sq_d;
      above_zero_q <= (row_q == '0);
    end
    if (qry_acc) begin
      addr21_q <= {qy2m1, qx1m1[ColW-1:0]};
      addr11_q <= {qy1m1[RowW-1:0], qx1m1[ColW-1:0]};
      z22_q    <= (qy2 == '0) || (qx2 == '0);
      z12_q    <= (y_start_i == '0) || (qx2 == '0);
      z21_q    <= (qy2 == '0) || (x_start_i == '0);
      z11_q    <= (y_start_i == '0) || (x_start_i == '0);
      status_q <= qstatus;
    end
    // first two corners, zero border applied
    if (state_q == StQryB) begin
      c22_sum_q <= z22_q ? '0 : rd_a_sum_q;
      c22_sq_q  <= z22_q ? '0 : rd_a_sq_q;
      c12_sum_q <= z12_q ? '0 : rd_b_sum_q;
      c12_sq_q  <= z12_q ? '0 : rd_b_sq_q;
    end
  end

  // Four-corner combination, masked by status and channel count
  always_comb begin
    for (int ch = 0; ch < Channels; ch++) begin
      res_sum_d[ch] = c22_sum_q[ch] - c12_sum_q[ch]
                    - (z21_q ? SumW'(0) : rd_a_sum_q[ch])
                    + (z11_q ? SumW'(0) : rd_b_sum_q[ch]);
      res_sq_d[ch]  = c22_sq_q[ch] - c12_sq_q[ch]
                    - (z21_q ? SqW'(0) : rd_a_sq_q[ch])
                    + (z11_q ? SqW'(0) : rd_b_sq_q[ch]);
      if (status_q != StatusOk || ch >= int'(eff_ch)) begin
        res_sum_d[ch] = '0;
        res_sq_d[ch]  = '0;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == StQryC);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == StQryC) begin
      res_sum_q <= res_sum_d;
      res_sq_q  <= res_sq_d;
      status_o  <= status_q;
    end
  end

  assign result_valid_o = valid_q;
  assign sum_c0_o       = res_sum_q[0];
  assign sum_c1_o       = res_sum_q[1];
  assign sum_c2_o       = res_sum_q[2];
  assign sq_c0_o        = res_sq_q[0];
  assign sq_c1_o        = res_sq_q[1];
  assign sq_c2_o        = res_sq_q[2];

endmodule

`default_nettype wire

// ===== rtl/iibs_checker.sv =====
// Port-level checker for the block-sum engine, bound to the top level.
`default_nettype none
`include "integral_image_block_sum_assert.svh"

module iibs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           opcode_i,
  input logic                           result_valid_o,
  input logic [iibs_pkg::SumW-1:0]      sum_c0_o,
  input logic [iibs_pkg::SumW-1:0]      sum_c1_o,
  input logic [iibs_pkg::SumW-1:0]      sum_c2_o,
  input logic [iibs_pkg::SqW-1:0]       sq_c0_o,
  input logic [iibs_pkg::SqW-1:0]       sq_c1_o,
  input logic [iibs_pkg::SqW-1:0]       sq_c2_o,
  input logic [iibs_pkg::StatusW-1:0]   status_o
);
  import iibs_pkg::*;

  logic qry_acc, load_acc, sums_zero;

  assign qry_acc   = start_i && !busy_o && (opcode_i == OpQuery);
  assign load_acc  = start_i && !busy_o && (opcode_i == OpLoad);
  assign sums_zero = (sum_c0_o == '0) && (sum_c1_o == '0) && (sum_c2_o == '0) &&
                     (sq_c0_o == '0) && (sq_c1_o == '0) && (sq_c2_o == '0);

  // a query keeps the block busy while its corners are read
  `IIBS_ASSERT_NEXT(a_query_busy, qry_acc, busy_o)
  // a load writes back next cycle and never produces a result there
  `IIBS_ASSERT_NEXT(a_load_busy, load_acc, busy_o && !result_valid_o)
  // each result is preceded by its accepted query
  `IIBS_ASSERT_SAME(a_result_latency, result_valid_o, $past(qry_acc, 3))
  // the block is free again when a result shows
  `IIBS_ASSERT_SAME(a_result_idle, result_valid_o, !busy_o)
  // flagged queries carry no sums
  `IIBS_ASSERT_SAME(a_flag_zero, result_valid_o && (status_o != StatusOk), sums_zero)

endmodule

bind integral_image_block_sum iibs_checker u_iibs_checker (.*);

`default_nettype wire
